// ===== rtl/core/buzzer_tone_mixer_macros.svh =====
// Assertion macros for the buzzer tone mixer.
// No dependencies; included by buzzer_tone_mixer.sv, the one file that checks its own logic.
`ifndef BUZZER_TONE_MIXER_MACROS_SVH
`define BUZZER_TONE_MIXER_MACROS_SVH
`ifndef SYNTHESIS
// Expression holds at every edge outside reset
`define BZM_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("bzm: check failed");
// Antecedent implies consequent in the same cycle
`define BZM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bzm: check failed");
// Antecedent implies consequent in the next cycle
`define BZM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bzm: check failed");
`else
`define BZM_ASSERT_HOLDS(label, clk, rst, expr)
`define BZM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BZM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/bzm_pkg.sv =====
// Shared types and constants of the buzzer tone mixer.
// No dependencies; used by the divider, the sine table and the top level.
package bzm_pkg;

   // Transaction kinds on the request channel
   localparam logic REQ_SETTINGS = 1'b0;
   localparam logic REQ_TICK     = 1'b1;

   // Control register indexes and widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 14;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUZZ_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWPASS_COEF = 2'd1;
   localparam logic [13:0] BUZZ_LEVEL_RST   = 14'd8000;
   localparam logic [7:0]  LOWPASS_COEF_RST = 8'd96;

   // Voice constants
   localparam int BUZZ_CLOCK_HZ  = 13000000;
   localparam int TONE_AMPLITUDE = 2600;
   localparam int ENV_FULL       = 256;
   localparam int ENV_DELTA      = 4;
   localparam int SINE_W         = 13;

   // Shared divider widths: dividend covers (13 MHz << 16), divisor the sample rate
   localparam int DIV_DIVIDEND_W = 40;
   localparam int DIV_DIVISOR_W  = 18;

   typedef struct packed {
      logic                      start;
      logic [DIV_DIVIDEND_W-1:0] dividend;
      logic [DIV_DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                      busy;
      logic                      done;
      logic [DIV_DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/buzzer_tone_mixer.sv =====
// Buzzer and two-tone mixer over one shared 18x18 multiplier and a bit-serial divider.
// Tick: envelope, buzzer, low-pass filter, tones and scaling give a registered sample
// (no tones when silent); ready again once it is registered. Settings: up to four
// divider jobs of 40 quotient bits each. One transaction at a time; a full output
// register holds the sequencer in its last state until the waiting sample is taken.
// Reset (synchronous): registers to 8000 and 96, voice state and output valid cleared.
`include "buzzer_tone_mixer_macros.svh"
module buzzer_tone_mixer #(
   parameter int SAMPLE_RATE_HZ = 48000,
   parameter int SINE_ENTRIES   = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic                               req_buzz_enable,
   input  logic [15:0]                        req_buzz_divider,
   input  logic [15:0]                        req_tone1_hz,
   input  logic [15:0]                        req_tone2_hz,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [15:0]                 rsp_pcm_sample,
   input  logic                               csr_wr_en,
   input  logic [bzm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bzm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IW = $clog2(SINE_ENTRIES);
   localparam int NW = bzm_pkg::DIV_DIVIDEND_W;
   localparam int DW = bzm_pkg::DIV_DIVISOR_W;
   localparam logic [DW-1:0] RATE_DIVISOR = DW'(SAMPLE_RATE_HZ);
   localparam logic signed [17:0] SINE_N = 18'(SINE_ENTRIES);
   localparam logic [8:0] ENV_FULL  = 9'(bzm_pkg::ENV_FULL);
   localparam logic [8:0] ENV_DELTA = 9'(bzm_pkg::ENV_DELTA);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_START, S_DIV_WAIT, S_TICK, S_LP1_MUL, S_LP1_ADD, S_LP2_MUL,
      S_LP2_ADD, S_T1_MUL, S_T1_ROM, S_T2_MUL, S_T2_ROM, S_SCALE_MUL, S_SAT
   } state_type;

   typedef enum logic [1:0] {
      JOB_FREQ, JOB_BUZZ, JOB_TONE1, JOB_TONE2
   } job_type;

   // Cached step: nonzero quotient kept modulo 2^16 in 1..65536
   function automatic logic [16:0] fold_step(input logic [NW-1:0] q);
      logic [16:0] r;
      r = '0;
      if (q != '0) begin
         r = {(q[15:0] == 16'd0), q[15:0]};
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   job_type   job_ff, job_in;

   logic [13:0]        buzz_level_ff, buzz_level_in;
   logic [7:0]         lowpass_coef_ff, lowpass_coef_in;
   logic [15:0]        buzz_phase_ff, buzz_phase_in;
   logic [15:0]        tone1_phase_ff, tone1_phase_in;
   logic [15:0]        tone2_phase_ff, tone2_phase_in;
   logic signed [15:0] lp1_ff, lp1_in;
   logic signed [15:0] lp2_ff, lp2_in;
   logic [8:0]         env_ff, env_in;
   logic               voiced_ff, voiced_in;
   logic [16:0]        buzz_step_ff, buzz_step_in;
   logic [16:0]        tone1_step_ff, tone1_step_in;
   logic [16:0]        tone2_step_ff, tone2_step_in;

   logic [15:0]        divider_ff, divider_in;
   logic [15:0]        f1_ff, f1_in;
   logic [15:0]        f2_ff, f2_in;
   logic               tone_on_ff, tone_on_in;
   logic [23:0]        freq_ff, freq_in;
   logic signed [14:0] sq_ff, sq_in;
   logic signed [17:0] acc_ff, acc_in;
   logic signed [35:0] prod_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_pcm_sample_ff, rsp_pcm_sample_in;

   logic               out_load;
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] mul_p;
   logic signed [35:0] prod_sh;
   logic signed [14:0] level_s;
   logic               buzz_on, tone_on;
   logic [IW-1:0]      rom_addr;
   logic signed [bzm_pkg::SINE_W-1:0] rom_data;

   bzm_pkg::div_req_type div_req;
   bzm_pkg::div_rsp_type div_rsp;

   bzm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bzm_sine_rom #(
      .ENTRIES (SINE_ENTRIES)
   ) u_sine_rom (
      .rom_addr (rom_addr),
      .rom_data (rom_data)
   );

   // Shared multiplier operand selection; product always registered
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_LP1_MUL: begin
            mul_a = $signed({10'd0, lowpass_coef_ff});
            mul_b = $signed({{3{sq_ff[14]}}, sq_ff}) - $signed({{2{lp1_ff[15]}}, lp1_ff});
         end
         S_LP2_MUL: begin
            mul_a = $signed({10'd0, lowpass_coef_ff});
            mul_b = $signed({{2{lp1_ff[15]}}, lp1_ff}) - $signed({{2{lp2_ff[15]}}, lp2_ff});
         end
         S_T1_MUL: begin
            mul_a = $signed({2'd0, tone1_phase_ff});
            mul_b = SINE_N;
         end
         S_T2_MUL: begin
            mul_a = $signed({2'd0, tone2_phase_ff});
            mul_b = SINE_N;
         end
         // Scaling operands stay selected while the sample waits for the output register
         S_SCALE_MUL, S_SAT: begin
            mul_a = acc_ff;
            mul_b = $signed({9'd0, env_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign prod_sh  = prod_ff >>> 8;
   assign rom_addr = prod_ff[16 +: IW];
   assign level_s  = $signed({1'b0, buzz_level_ff});
   assign buzz_on  = req_buzz_enable && (req_buzz_divider != 16'd0);
   assign tone_on  = (req_tone1_hz != 16'd0);
   assign out_load = (state_ff == S_SAT) && (!rsp_valid_ff || rsp_ready);

   // Divider request for the current job
   always_comb begin
      div_req.start    = (state_ff == S_DIV_START);
      div_req.dividend = '0;
      div_req.divisor  = RATE_DIVISOR;
      unique case (job_ff)
         JOB_FREQ: begin
            div_req.dividend = NW'(bzm_pkg::BUZZ_CLOCK_HZ);
            div_req.divisor  = DW'(divider_ff);
         end
         JOB_BUZZ:  div_req.dividend = {freq_ff, 16'd0};
         JOB_TONE1: div_req.dividend = {8'd0, f1_ff, 16'd0};
         JOB_TONE2: div_req.dividend = {8'd0, f2_ff, 16'd0};
         default:   div_req.dividend = '0;
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in          = state_ff;
      job_in            = job_ff;
      buzz_level_in     = buzz_level_ff;
      lowpass_coef_in   = lowpass_coef_ff;
      buzz_phase_in     = buzz_phase_ff;
      tone1_phase_in    = tone1_phase_ff;
      tone2_phase_in    = tone2_phase_ff;
      lp1_in            = lp1_ff;
      lp2_in            = lp2_ff;
      env_in            = env_ff;
      voiced_in         = voiced_ff;
      buzz_step_in      = buzz_step_ff;
      tone1_step_in     = tone1_step_ff;
      tone2_step_in     = tone2_step_ff;
      divider_in        = divider_ff;
      f1_in             = f1_ff;
      f2_in             = f2_ff;
      tone_on_in        = tone_on_ff;
      freq_in           = freq_ff;
      sq_in             = sq_ff;
      acc_in            = acc_ff;
      rsp_pcm_sample_in = rsp_pcm_sample_ff;
      rsp_valid_in      = rsp_ready ? 1'b0 : rsp_valid_ff;

      // Control register writes
      if (csr_wr_en) begin
         priority if (csr_index == bzm_pkg::CSR_BUZZ_LEVEL) begin
            buzz_level_in = csr_wdata[13:0];
         end else if (csr_index == bzm_pkg::CSR_LOWPASS_COEF) begin
            lowpass_coef_in = csr_wdata[7:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_type == bzm_pkg::REQ_TICK) begin
                  state_in = S_TICK;
               end else begin
                  // Settings: latch the voice and, if anything is voiced, start the step divisions
                  voiced_in  = buzz_on || tone_on;
                  divider_in = req_buzz_divider;
                  f1_in      = req_tone1_hz;
                  f2_in      = req_tone2_hz;
                  tone_on_in = tone_on;
                  if (buzz_on || tone_on) begin
                     buzz_step_in  = '0;
                     tone1_step_in = '0;
                     tone2_step_in = '0;
                     job_in        = buzz_on ? JOB_FREQ : JOB_TONE1;
                     state_in      = S_DIV_START;
                  end
               end
            end
         end
         S_DIV_START: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               unique case (job_ff)
                  JOB_FREQ: begin
                     freq_in  = div_rsp.quotient[23:0];
                     job_in   = JOB_BUZZ;
                     state_in = S_DIV_START;
                  end
                  JOB_BUZZ: begin
                     buzz_step_in = fold_step(div_rsp.quotient);
                     job_in       = JOB_TONE1;
                     state_in     = tone_on_ff ? S_DIV_START : S_IDLE;
                  end
                  JOB_TONE1: begin
                     tone1_step_in = fold_step(div_rsp.quotient);
                     job_in        = JOB_TONE2;
                     state_in      = (f2_ff != 16'd0) ? S_DIV_START : S_IDLE;
                  end
                  JOB_TONE2: begin
                     tone2_step_in = fold_step(div_rsp.quotient);
                     state_in      = S_IDLE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_TICK: begin
            // Envelope step and buzzer square
            if (voiced_ff) begin
               if (env_ff < ENV_FULL) begin
                  env_in = env_ff + ENV_DELTA;
               end
            end else if (env_ff >= ENV_DELTA) begin
               env_in = env_ff - ENV_DELTA;
            end else begin
               env_in = '0;
            end
            buzz_phase_in = buzz_phase_ff + buzz_step_ff[15:0];
            if (buzz_step_ff == '0) begin
               sq_in = '0;
            end else begin
               sq_in = buzz_phase_in[15] ? -level_s : level_s;
            end
            state_in = S_LP1_MUL;
         end
         S_LP1_MUL: state_in = S_LP1_ADD;
         S_LP1_ADD: begin
            lp1_in   = lp1_ff + prod_sh[15:0];
            state_in = S_LP2_MUL;
         end
         S_LP2_MUL: state_in = S_LP2_ADD;
         S_LP2_ADD: begin
            lp2_in = lp2_ff + prod_sh[15:0];
            acc_in = $signed({{2{lp2_in[15]}}, lp2_in});
            // Silent envelope: tones hold, scaling by zero gives silence
            if (env_ff != '0) begin
               tone1_phase_in = tone1_phase_ff + tone1_step_ff[15:0];
               tone2_phase_in = tone2_phase_ff + tone2_step_ff[15:0];
               state_in       = S_T1_MUL;
            end else begin
               state_in = S_SCALE_MUL;
            end
         end
         S_T1_MUL: state_in = (tone1_step_ff != '0) ? S_T1_ROM : S_T2_MUL;
         S_T1_ROM: begin
            acc_in   = acc_ff + 18'(rom_data);
            state_in = S_T2_MUL;
         end
         S_T2_MUL: state_in = (tone2_step_ff != '0) ? S_T2_ROM : S_SCALE_MUL;
         S_T2_ROM: begin
            acc_in   = acc_ff + 18'(rom_data);
            state_in = S_SCALE_MUL;
         end
         S_SCALE_MUL: state_in = S_SAT;
         S_SAT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               if (prod_sh > 36'sd32767) begin
                  rsp_pcm_sample_in = 16'sh7FFF;
               end else if (prod_sh < -36'sd32768) begin
                  rsp_pcm_sample_in = 16'sh8000;
               end else begin
                  rsp_pcm_sample_in = prod_sh[15:0];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, voice registers and output register
   always_ff @(posedge clock) begin
      prod_ff           <= mul_p;
      divider_ff        <= divider_in;
      f1_ff             <= f1_in;
      f2_ff             <= f2_in;
      tone_on_ff        <= tone_on_in;
      freq_ff           <= freq_in;
      sq_ff             <= sq_in;
      acc_ff            <= acc_in;
      job_ff            <= job_in;
      rsp_pcm_sample_ff <= rsp_pcm_sample_in;
      if (reset) begin
         state_ff        <= S_IDLE;
         buzz_level_ff   <= bzm_pkg::BUZZ_LEVEL_RST;
         lowpass_coef_ff <= bzm_pkg::LOWPASS_COEF_RST;
         buzz_phase_ff   <= '0;
         tone1_phase_ff  <= '0;
         tone2_phase_ff  <= '0;
         lp1_ff          <= '0;
         lp2_ff          <= '0;
         env_ff          <= '0;
         voiced_ff       <= 1'b0;
         buzz_step_ff    <= '0;
         tone1_step_ff   <= '0;
         tone2_step_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         buzz_level_ff   <= buzz_level_in;
         lowpass_coef_ff <= lowpass_coef_in;
         buzz_phase_ff   <= buzz_phase_in;
         tone1_phase_ff  <= tone1_phase_in;
         tone2_phase_ff  <= tone2_phase_in;
         lp1_ff          <= lp1_in;
         lp2_ff          <= lp2_in;
         env_ff          <= env_in;
         voiced_ff       <= voiced_in;
         buzz_step_ff    <= buzz_step_in;
         tone1_step_ff   <= tone1_step_in;
         tone2_step_ff   <= tone2_step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pcm_sample = rsp_pcm_sample_ff;

   // Envelope stays within full scale
   `BZM_ASSERT_HOLDS(a_env_range, clock, reset, env_ff <= ENV_FULL)
   // Divider is never left running once the sequencer is idle
   `BZM_ASSERT_IMPLIES(a_div_idle, clock, reset, state_ff == S_IDLE, !div_rsp.busy)
   // A silent envelope always yields a zero sample
   `BZM_ASSERT_NEXT(a_silent_zero, clock, reset, out_load && env_ff == '0, rsp_pcm_sample_ff == '0)

endmodule

// ===== rtl/core/bzm_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bzm_pkg for widths and the request/status structs.
module bzm_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  bzm_pkg::div_req_type div_req,
   output bzm_pkg::div_rsp_type div_rsp
);

   localparam int NW = bzm_pkg::DIV_DIVIDEND_W;
   localparam int DW = bzm_pkg::DIV_DIVISOR_W;
   localparam int CW = $clog2(NW);
   localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] divisor_ff, divisor_in;
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   rem_shift;
   logic [DW+1:0] trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, quo_ff[NW-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, divisor_ff};

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         count_in   = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DW+1]) begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/bzm_sine_rom.sv =====
// Sine table of the tone voices (Bhaskara approximation, truncated toward zero).
// Depends on bzm_pkg for the amplitude; stores one quarter wave, ENTRIES a multiple of 4.
module bzm_sine_rom #(
   parameter int ENTRIES = 256
) (
   input  logic [$clog2(ENTRIES)-1:0]        rom_addr,
   output logic signed [bzm_pkg::SINE_W-1:0] rom_data
);

   localparam int IW = $clog2(ENTRIES);
   localparam int QN = ENTRIES / 4 + 1;
   localparam int KW = $clog2(QN);
   localparam int MW = bzm_pkg::SINE_W - 1;
   localparam logic [IW-1:0] HALF  = IW'(ENTRIES / 2);
   localparam logic [IW-1:0] QUART = IW'(ENTRIES / 4);

   logic [MW-1:0] quarter [QN];
   logic          neg_half;
   logic [IW-1:0] half_idx;
   logic [IW-1:0] quart_idx;
   logic [MW-1:0] mag;

   // Quarter-wave magnitudes worked out at elaboration
   for (genvar k = 0; k < QN; k++) begin : g_quarter
      localparam longint NUM = 360 * longint'(k) * (180 * longint'(ENTRIES) - 360 * longint'(k));
      localparam longint DEN = 40500 * longint'(ENTRIES) * longint'(ENTRIES) - NUM;
      localparam longint MAG = 4 * longint'(bzm_pkg::TONE_AMPLITUDE) * NUM / DEN;
      assign quarter[k] = MW'(MAG);
   end

   // Fold the address into the first quarter; second half is the negated first half
   assign neg_half  = (rom_addr >= HALF);
   assign half_idx  = neg_half ? (rom_addr - HALF) : rom_addr;
   assign quart_idx = (half_idx > QUART) ? (HALF - half_idx) : half_idx;
   assign mag       = quarter[quart_idx[KW-1:0]];
   assign rom_data  = neg_half ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// ===== test/buzzer_tone_mixer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the buzzer tone mixer: watches the request, result and register ports,
// predicts every tick sample and compares it with the block's output in order.
// Depends on bzm_pkg for transaction kinds, register indexes and voice constants.
module buzzer_tone_mixer_checker #(
   parameter int SAMPLE_RATE_HZ = 48000,
   parameter int SINE_ENTRIES   = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_type,
   input  logic                            req_buzz_enable,
   input  logic [15:0]                     req_buzz_divider,
   input  logic [15:0]                     req_tone1_hz,
   input  logic [15:0]                     req_tone2_hz,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic signed [15:0]              rsp_pcm_sample,
   input  logic                            csr_wr_en,
   input  logic [bzm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bzm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              error_count,
   output int                              samples_pending
);
   import bzm_pkg::*;

   // Predicted register and voice state
   logic [13:0]        level_q;
   logic [7:0]         coef_q;
   logic [15:0]        buzz_ph, tone1_ph, tone2_ph;
   logic signed [15:0] lp_first, lp_second;
   logic [8:0]         env_level;
   logic               voiced;
   logic [16:0]        buzz_rate, tone1_inc, tone2_inc;

   // Samples predicted but not yet seen on the result channel
   logic signed [15:0] pcm_due_q[$];

   // Nonzero steps are kept as ((step - 1) mod 2^16) + 1
   function automatic logic [16:0] fold_phase_step(input longint unsigned raw);
      logic [15:0] low;
      if (raw == 0) return '0;
      low = 16'(raw - 1);
      return {1'b0, low} + 17'd1;
   endfunction

   // Bhaskara sine approximation, truncated toward zero
   function automatic int sine_table_value(input logic [15:0] phase);
      longint unsigned n, i, num, den, q;
      n = SINE_ENTRIES;
      i = (longint'(phase) * SINE_ENTRIES) >> 16;
      if (i >= n) i = n - 1;
      if (2 * i <= n) begin
         num = 360 * i * (180 * n - 360 * i);
         den = 40500 * n * n - num;
         q = (4 * TONE_AMPLITUDE * num) / den;
         return int'(q);
      end
      num = (360 * i - 180 * n) * (360 * n - 360 * i);
      den = 40500 * n * n - num;
      q = (4 * TONE_AMPLITUDE * num) / den;
      return -int'(q);
   endfunction

   // Settings transaction: steps are replaced only when something is voiced
   function automatic void load_voice_settings(input logic en, input logic [15:0] div,
                                               input logic [15:0] f1, input logic [15:0] f2);
      logic            buzz_on, tone_on;
      longint unsigned hz;
      buzz_on = en && (div != 0);
      tone_on = (f1 != 0);
      voiced  = buzz_on || tone_on;
      if (voiced) begin
         buzz_rate = '0;
         tone1_inc = '0;
         tone2_inc = '0;
         if (buzz_on) begin
            hz = BUZZ_CLOCK_HZ;
            hz = hz / div;
            buzz_rate = fold_phase_step((hz << 16) / SAMPLE_RATE_HZ);
         end
         if (tone_on) begin
            hz = f1;
            tone1_inc = fold_phase_step((hz << 16) / SAMPLE_RATE_HZ);
            if (f2 != 0) begin
               hz = f2;
               tone2_inc = fold_phase_step((hz << 16) / SAMPLE_RATE_HZ);
            end
         end
      end
   endfunction

   // Tick transaction: envelope, filtered buzzer square, tones, scaling
   function automatic logic signed [15:0] mix_tick_sample();
      int square, coef, mix, scaled;
      square = 0;
      coef = int'(coef_q);
      if (voiced) begin
         if (env_level < ENV_FULL) env_level = env_level + 9'(ENV_DELTA);
      end else if (env_level >= ENV_DELTA) begin
         env_level = env_level - 9'(ENV_DELTA);
      end else begin
         env_level = '0;
      end

      if (buzz_rate != 0) begin
         buzz_ph = buzz_ph + buzz_rate[15:0];
         square = buzz_ph[15] ? -int'(level_q) : int'(level_q);
      end
      // two cascaded one-pole stages, floor division by 256
      lp_first  = 16'(int'(lp_first) + ((coef * (square - int'(lp_first))) >>> 8));
      lp_second = 16'(int'(lp_second) + ((coef * (int'(lp_first) - int'(lp_second))) >>> 8));

      // silent envelope: output zero, tone phases hold
      if (env_level == 0) return '0;

      mix = int'(lp_second);
      if (tone1_inc != 0) begin
         tone1_ph = tone1_ph + tone1_inc[15:0];
         mix += sine_table_value(tone1_ph);
      end
      if (tone2_inc != 0) begin
         tone2_ph = tone2_ph + tone2_inc[15:0];
         mix += sine_table_value(tone2_ph);
      end
      scaled = (mix * int'(env_level)) >>> 8;
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      return 16'(scaled);
   endfunction

   // Register writes, then results, then new requests within one edge
   always @(posedge clock) begin
      logic signed [15:0] due;
      if (reset) begin
         level_q     = BUZZ_LEVEL_RST;
         coef_q      = LOWPASS_COEF_RST;
         buzz_ph     = '0;
         tone1_ph    = '0;
         tone2_ph    = '0;
         lp_first    = '0;
         lp_second   = '0;
         env_level   = '0;
         voiced      = 1'b0;
         buzz_rate   = '0;
         tone1_inc   = '0;
         tone2_inc   = '0;
         error_count = 0;
         pcm_due_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_BUZZ_LEVEL) level_q = csr_wdata[13:0];
            else if (csr_index == CSR_LOWPASS_COEF) coef_q = csr_wdata[7:0];
         end

         if (rsp_valid && rsp_ready) begin
            if (pcm_due_q.size() == 0) begin
               error_count++;
               $display("%0t: pcm_sample %0d arrived with no tick outstanding",
                        $time, rsp_pcm_sample);
            end else begin
               due = pcm_due_q.pop_front();
               if (due !== rsp_pcm_sample) begin
                  error_count++;
                  $display("%0t: pcm_sample mismatch, expected %0d, got %0d",
                           $time, due, rsp_pcm_sample);
               end
            end
         end

         if (req_valid && req_ready) begin
            if (req_type == REQ_TICK) pcm_due_q.push_back(mix_tick_sample());
            else load_voice_settings(req_buzz_enable, req_buzz_divider,
                                     req_tone1_hz, req_tone2_hz);
         end
      end
      samples_pending <= pcm_due_q.size();
   end

endmodule

// ===== test/buzzer_tone_mixer_tb.sv =====
`timescale 1ns / 1ps
// Top of the buzzer tone mixer testbench: clock, reset, stimulus and verdict.
// Depends on bzm_pkg, the block and buzzer_tone_mixer_checker, which does the comparing.
module buzzer_tone_mixer_tb;
   import bzm_pkg::*;

   localparam int SAMPLE_RATE  = 48000;
   localparam int SINE_SIZE    = 256;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_CYCLES = 200;   // longest settings transaction plus margin
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 180;
   localparam int HOLD_AT      = 300;    // result count at which the receiver stalls
   localparam int HOLD_CYCLES  = 400;

   // Register indexes the block does not decode
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic        kind;
      logic        buzz_en;
      logic [15:0] divider;
      logic [15:0] tone1;
      logic [15:0] tone2;
   } voice_req_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_type;
   logic                    req_buzz_enable;
   logic [15:0]             req_buzz_divider;
   logic [15:0]             req_tone1_hz;
   logic [15:0]             req_tone2_hz;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [15:0]      rsp_pcm_sample;
   logic                    csr_wr_en;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   int error_count;
   int samples_pending;
   int cycles;
   int items_sent;
   int ticks_sent;
   int settings_sent;
   int csr_writes;

   buzzer_tone_mixer #(
      .SAMPLE_RATE_HZ (SAMPLE_RATE),
      .SINE_ENTRIES   (SINE_SIZE)
   ) DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_buzz_enable,
      .req_buzz_divider, .req_tone1_hz, .req_tone2_hz,
      .rsp_valid, .rsp_ready, .rsp_pcm_sample,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   buzzer_tone_mixer_checker #(
      .SAMPLE_RATE_HZ (SAMPLE_RATE),
      .SINE_ENTRIES   (SINE_SIZE)
   ) pcm_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_buzz_enable,
      .req_buzz_divider, .req_tone1_hz, .req_tone2_hz,
      .rsp_valid, .rsp_ready, .rsp_pcm_sample,
      .csr_wr_en, .csr_index, .csr_wdata,
      .error_count, .samples_pending
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit
   initial begin
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: cycle limit reached with %0d samples outstanding", $time, samples_pending);
      $display("buzzer_tone_mixer_tb NOT OK");
      $finish;
   end

   // Result side: random stalls, bursts without any, and one long hold-off
   initial begin
      int gap;
      int taken;
      taken = 0;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ((taken / 40) % 4 == 2) ? 0 : $urandom_range(0, 5);
         if (taken == HOLD_AT) gap = HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   // Tick with junk in the fields it does not use
   function automatic voice_req_type make_tick();
      voice_req_type r;
      r.kind    = REQ_TICK;
      r.buzz_en = 1'($urandom);
      r.divider = 16'($urandom);
      r.tone1   = 16'($urandom);
      r.tone2   = 16'($urandom);
      return r;
   endfunction

   function automatic voice_req_type make_settings(input logic en, input logic [15:0] div,
                                                   input logic [15:0] f1,
                                                   input logic [15:0] f2);
      voice_req_type r;
      r.kind    = REQ_SETTINGS;
      r.buzz_en = en;
      r.divider = div;
      r.tone1   = f1;
      r.tone2   = f2;
      return r;
   endfunction

   // Mostly audible pitches, sometimes the full field
   function automatic logic [15:0] pick_hz();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(20, 5000));
   endfunction

   function automatic logic [15:0] pick_divider();
      if ($urandom_range(0, 1) == 0) return 16'($urandom);
      return 16'($urandom_range(1000, 30000));
   endfunction

   // Mostly ticks so the envelope ramps fully; voicing and ring-down now and then
   function automatic voice_req_type random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 6)
         return make_settings($urandom_range(0, 3) != 0, pick_divider(),
                              ($urandom_range(0, 2) != 0) ? pick_hz() : 16'd0,
                              ($urandom_range(0, 3) != 0) ? pick_hz() : 16'd0);
      if (pick < 9)
         return make_settings(1'b0, 16'($urandom), 16'd0, 16'($urandom));
      return make_tick();
   endfunction

   // Offer one request transaction and hold it until accepted
   task automatic send_item(input voice_req_type item);
      int gap;
      gap = ((items_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= item.kind;
      req_buzz_enable  <= item.buzz_en;
      req_buzz_divider <= item.divider;
      req_tone1_hz     <= item.tone1;
      req_tone2_hz     <= item.tone2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (item.kind == REQ_TICK) ticks_sent++;
      else settings_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (samples_pending != 0) @(posedge clock);
   endtask

   // Registers change only once the block is idle
   task automatic program_csr(input logic [13:0] level, input logic [13:0] coef_data,
                              input logic with_spare);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BUZZ_LEVEL;
      csr_wdata <= level;
      @(posedge clock);
      csr_index <= CSR_LOWPASS_COEF;
      csr_wdata <= coef_data;
      @(posedge clock);
      csr_writes += 2;
      if (with_spare) begin
         csr_index <= CSR_SPARE_A;
         csr_wdata <= 14'($urandom);
         @(posedge clock);
         csr_index <= CSR_SPARE_B;
         csr_wdata <= 14'($urandom);
         @(posedge clock);
         csr_writes += 2;
      end
      csr_wr_en <= 1'b0;
   endtask

   // Stimulus and verdict
   initial begin
      logic [13:0] level;
      logic [13:0] coef_data;
      items_sent       = 0;
      ticks_sent       = 0;
      settings_sent    = 0;
      csr_writes       = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_SETTINGS;
      req_buzz_enable  = 1'b0;
      req_buzz_divider = '0;
      req_tone1_hz     = '0;
      req_tone2_hz     = '0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_BUZZ_LEVEL;
      csr_wdata        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: silent envelope after reset, field extremes, ring-down on cached steps
      send_item(make_tick());
      send_item(make_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF) ^ 50'd0 | {REQ_TICK, 49'd0});
      send_item(make_settings(1'b1, 16'd0, 16'd0, 16'd0));
      send_item(make_tick());
      send_item(make_settings(1'b1, 16'd1, 16'd0, 16'hFFFF));
      send_item(make_tick());
      send_item(make_tick());
      send_item(make_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_item(make_tick());
      send_item(make_tick());
      send_item(make_settings(1'b1, 16'hFFFF, 16'd1, 16'd0));
      send_item(make_tick());
      send_item(make_tick());
      send_item(make_settings(1'b1, 16'd1, 16'd440, 16'd880));
      send_item(make_tick());
      send_item(make_tick());
      send_item(make_tick());
      send_item(make_settings(1'b0, 16'd0, 16'd0, 16'hFFFF));
      send_item(make_tick());
      send_item(make_tick());
      send_item(make_settings(1'b0, 16'd2000, 16'd0, 16'd0));
      send_item(make_tick());
      send_item(make_tick());

      // Random phases, each under its own register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin level = 14'h3FFF; coef_data = 14'h3FFF; end
            1: begin level = 14'd0;    coef_data = 14'd0;    end
            2: begin level = BUZZ_LEVEL_RST; coef_data = 14'(LOWPASS_COEF_RST); end
            default: begin level = 14'($urandom); coef_data = 14'($urandom); end
         endcase
         program_csr(level, coef_data, phase == 0 || phase == PHASES - 1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // sender pauses once until every sample is back
            if (phase == 2 && k == 90) drain_results();
            send_item(random_item());
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d settings and %0d tick transactions across %0d register settings",
               settings_sent, ticks_sent, PHASES + 1);
      $display("with %0d register writes, a %0d-cycle receiver hold-off and a mid-run drain",
               csr_writes, HOLD_CYCLES);
      if (error_count == 0)
         $display("buzzer_tone_mixer_tb OK");
      else
         $display("buzzer_tone_mixer_tb NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/bzm_pkg.sv
rtl/core/bzm_divider.sv
rtl/core/bzm_sine_rom.sv
rtl/core/buzzer_tone_mixer.sv
test/buzzer_tone_mixer_checker.sv
test/buzzer_tone_mixer_tb.sv
